[sv/pa3_pkg.sv]
// Shared widths and constants for the polygon area block.
package pa3_pkg;

  localparam int VW        = 24;   // vertex coordinate
  localparam int DW        = 25;   // coordinate difference
  localparam int NW        = 51;   // cross component, signed
  localparam int CSW       = 64;   // cross sum, signed integer
  localparam int MUL_AW    = 64;   // multiplier operand a, signed
  localparam int MUL_BW    = 32;   // multiplier operand b, signed
  localparam int PROD_W    = MUL_AW + MUL_BW + 1;
  localparam int MUL_CNT_W = $clog2(MUL_BW);
  localparam int SQ_W      = 64;   // radicand
  localparam int ROOT_W    = 32;
  localparam int SQRT_STEPS = SQ_W / 2;
  localparam int SQRT_CNT_W = $clog2(SQRT_STEPS);
  localparam int DIV_NW    = 64;   // dividend
  localparam int DIV_DW    = 32;   // divisor
  localparam int DIV_CNT_W = $clog2(DIV_NW);
  localparam int NRM_W     = 32;   // Q1.30
  localparam int DACC_W    = PROD_W + 1;
  localparam int FRAC_SH   = 31;
  localparam int NORM_HI   = 30;
  localparam int NORM_LO   = 29;

  localparam logic [NRM_W-1:0] ONE_Q30 = NRM_W'(1) << NORM_HI;
  localparam logic signed [CSW-1:0] CS_MAX = {1'b0, {(CSW-1){1'b1}}};
  localparam logic signed [CSW-1:0] CS_MIN = {1'b1, {(CSW-1){1'b0}}};

endpackage

[sv/polygon_area_3d_core.sv]
// Signed area and unit normal of a planar 3D polygon, serial datapath.
// Per non-final vertex after the first: six products on one shift-add multiplier, one bit per cycle,
// plus bookkeeping; a final vertex adds the closing cross, the normal, up to 29 normalizing
// shifts, squares, root, three divides and dot.
// Throughput: one vertex at a time; the result word waits in an output register.
// Reset: synchronous active-low rst_n clears control, vertex count and cross sums.
module polygon_area_3d_core (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [pa3_pkg::VW-1:0]        in_vx,
  input  logic signed [pa3_pkg::VW-1:0]        in_vy,
  input  logic signed [pa3_pkg::VW-1:0]        in_vz,
  input  logic                                 in_last,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [pa3_pkg::CSW-1:0]       out_area,
  output logic signed [pa3_pkg::NRM_W-1:0]     out_normal_x,
  output logic signed [pa3_pkg::NRM_W-1:0]     out_normal_y,
  output logic signed [pa3_pkg::NRM_W-1:0]     out_normal_z,
  output logic                                 out_degenerate
);

  localparam int VW  = pa3_pkg::VW;
  localparam int DW  = pa3_pkg::DW;
  localparam int NW  = pa3_pkg::NW;
  localparam int CSW = pa3_pkg::CSW;

  typedef enum logic [17:0] {
    S_IDLE   = 18'h00001,
    S_VTX    = 18'h00002,
    S_MUL    = 18'h00004,
    S_MWAIT  = 18'h00008,
    S_UPD    = 18'h00010,
    S_CLOSED = 18'h00020,
    S_NZ     = 18'h00040,
    S_NORM   = 18'h00080,
    S_SQ     = 18'h00100,
    S_SQW    = 18'h00200,
    S_ROOT   = 18'h00400,
    S_ROOTW  = 18'h00800,
    S_DIV    = 18'h01000,
    S_DIVW   = 18'h02000,
    S_DOT    = 18'h04000,
    S_DOTW   = 18'h08000,
    S_FIN    = 18'h10000,
    S_EMIT   = 18'h20000
  } state_t;

  // Which cross product the shared multiplier sequence is working on.
  typedef enum logic [1:0] {
    JOB_EDGE   = 2'd0,   // prev x cur, into the running sum
    JOB_CLOSE  = 2'd1,   // cur x first vertex, into the running sum
    JOB_NORMAL = 2'd2    // (v0-v1) x (v2-v1), into the normal
  } job_t;

  state_t state_r;
  job_t   job_r;
  logic [1:0] k_r;       // component index
  logic       h_r;       // which of the two products of a component
  logic [1:0] cnt_r;     // vertices seen, saturates at three
  logic       last_r;

  logic signed [VW-1:0]  cur_r  [3];
  logic signed [VW-1:0]  prev_r [3];
  logic signed [VW-1:0]  anc_r  [3][3];
  logic signed [CSW-1:0] cs_r   [3];
  logic signed [NW-1:0]  n_r    [3];
  logic [NW-1:0]         m_r    [3];
  logic signed [pa3_pkg::NRM_W-1:0] nrm_r [3];
  logic signed [NW-2:0]  tmp_r;
  logic [pa3_pkg::SQ_W-1:0]   sq_r;
  logic [pa3_pkg::ROOT_W-1:0] root_r;
  logic signed [pa3_pkg::DACC_W-1:0] dacc_r;
  logic signed [CSW-1:0] area_r;
  logic                  deg_r;
  logic                  out_valid_r;

  // Cross operand vectors and per-component picks.
  logic signed [DW-1:0] xv [3];
  logic signed [DW-1:0] yv [3];
  logic signed [DW-1:0] xa, yb, ya, xb, op_a, op_b;
  logic signed [CSW-1:0] cs_k;
  logic signed [NW-1:0]  n_k;
  logic [NW-1:0]         m_k;
  logic signed [pa3_pkg::NRM_W-1:0] nrm_k;

  // Shared units.
  logic                                  mul_start, mul_done;
  logic signed [pa3_pkg::MUL_AW-1:0]     mul_a;
  logic signed [pa3_pkg::MUL_BW-1:0]     mul_b;
  logic signed [pa3_pkg::PROD_W-1:0]     prod;
  logic                                  sqrt_done;
  logic [pa3_pkg::ROOT_W-1:0]            sqrt_root;
  logic                                  div_done;
  logic [pa3_pkg::DIV_NW-1:0]            div_num, quo;

  // Datapath helpers.
  logic signed [NW-1:0]  comp;
  logic signed [CSW:0]   s65;
  logic signed [CSW-1:0] cs_sat;
  logic                  any_hi, all_lo, all_zero;
  logic [pa3_pkg::NRM_W-1:0] q_clamp;
  logic signed [pa3_pkg::NRM_W-1:0] q_signed;
  logic signed [pa3_pkg::DACC_W-1:0] dacc_rnd;
  logic signed [pa3_pkg::DACC_W-pa3_pkg::FRAC_SH-1:0] area_sh;
  logic signed [CSW-1:0] area_sat;
  logic                  out_take;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      case (job_r)
        JOB_CLOSE: begin
          xv[i] = DW'(cur_r[i]);
          yv[i] = DW'(anc_r[0][i]);
        end
        JOB_NORMAL: begin
          xv[i] = DW'(anc_r[0][i]) - DW'(anc_r[1][i]);
          yv[i] = DW'(anc_r[2][i]) - DW'(anc_r[1][i]);
        end
        default: begin
          xv[i] = DW'(prev_r[i]);
          yv[i] = DW'(cur_r[i]);
        end
      endcase
    end
  end

  // Component k is x[i]*y[j] - y[i]*x[j] with (i,j) cycling (1,2), (2,0), (0,1).
  always_comb begin
    case (k_r)
      2'd1: begin
        xa = xv[2]; yb = yv[0]; ya = yv[2]; xb = xv[0];
        cs_k = cs_r[1]; n_k = n_r[1]; m_k = m_r[1]; nrm_k = nrm_r[1];
      end
      2'd2: begin
        xa = xv[0]; yb = yv[1]; ya = yv[0]; xb = xv[1];
        cs_k = cs_r[2]; n_k = n_r[2]; m_k = m_r[2]; nrm_k = nrm_r[2];
      end
      default: begin
        xa = xv[1]; yb = yv[2]; ya = yv[1]; xb = xv[2];
        cs_k = cs_r[0]; n_k = n_r[0]; m_k = m_r[0]; nrm_k = nrm_r[0];
      end
    endcase
    op_a = h_r ? ya : xa;
    op_b = h_r ? xb : yb;
  end

  // Feed the multiplier according to the phase.
  always_comb begin
    mul_start = 1'b0;
    mul_a     = pa3_pkg::MUL_AW'(op_a);
    mul_b     = pa3_pkg::MUL_BW'(op_b);
    case (state_r)
      S_MUL: mul_start = 1'b1;
      S_SQ: begin
        mul_start = 1'b1;
        mul_a     = pa3_pkg::MUL_AW'(m_k);
        mul_b     = m_k[pa3_pkg::MUL_BW-1:0];
      end
      S_DOT: begin
        mul_start = 1'b1;
        mul_a     = cs_k;
        mul_b     = nrm_k;
      end
      default: mul_start = 1'b0;
    endcase
  end

  pa3_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (prod)
  );

  pa3_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (state_r == S_ROOT),
    .x     (sq_r),
    .done  (sqrt_done),
    .root  (sqrt_root)
  );

  // Dividend: m * 2^30 plus half the root, for round half up.
  assign div_num = {m_k[pa3_pkg::DIV_NW-pa3_pkg::NORM_HI-1:0], pa3_pkg::NORM_HI'(0)}
                 + pa3_pkg::DIV_NW'(root_r >> 1);

  pa3_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (state_r == S_DIV),
    .num   (div_num),
    .den   (root_r),
    .done  (div_done),
    .quo   (quo)
  );

  // Second product completes a component; for the sum jobs, saturate it into the running sum.
  assign comp   = NW'(tmp_r) - prod[NW-1:0];
  assign s65    = {cs_k[CSW-1], cs_k} + (CSW+1)'(comp);
  assign cs_sat = (s65[CSW] != s65[CSW-1]) ?
                  (s65[CSW] ? pa3_pkg::CS_MIN : pa3_pkg::CS_MAX) : s65[CSW-1:0];

  // Normalize window tests on the magnitudes.
  assign any_hi   = (|m_r[0][NW-1:pa3_pkg::NORM_HI]) | (|m_r[1][NW-1:pa3_pkg::NORM_HI])
                  | (|m_r[2][NW-1:pa3_pkg::NORM_HI]);
  assign all_lo   = ~((|m_r[0][NW-1:pa3_pkg::NORM_LO]) | (|m_r[1][NW-1:pa3_pkg::NORM_LO])
                  | (|m_r[2][NW-1:pa3_pkg::NORM_LO]));
  assign all_zero = (n_r[0] == '0) && (n_r[1] == '0) && (n_r[2] == '0);

  // Clamp the quotient to one and give it the component's sign.
  assign q_clamp  = ((|quo[pa3_pkg::DIV_NW-1:pa3_pkg::NORM_HI+1])
                    || (quo[pa3_pkg::NORM_HI] && (|quo[pa3_pkg::NORM_HI-1:0])))
                    ? pa3_pkg::ONE_Q30 : quo[pa3_pkg::NRM_W-1:0];
  assign q_signed = n_k[NW-1] ? -$signed(q_clamp) : $signed(q_clamp);

  // Round half up, drop 31 fraction bits, saturate to 64 bits.
  assign dacc_rnd = dacc_r + (pa3_pkg::DACC_W'(1) << (pa3_pkg::FRAC_SH - 1));
  assign area_sh  = dacc_rnd[pa3_pkg::DACC_W-1:pa3_pkg::FRAC_SH];
  always_comb begin
    if (area_sh[$bits(area_sh)-1:CSW-1] == '0 || area_sh[$bits(area_sh)-1:CSW-1] == '1) begin
      area_sat = area_sh[CSW-1:0];
    end else begin
      area_sat = area_sh[$bits(area_sh)-1] ? pa3_pkg::CS_MIN : pa3_pkg::CS_MAX;
    end
  end

  assign out_take = out_valid_r && !out_stall;
  assign in_stall = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      job_r       <= JOB_EDGE;
      k_r         <= '0;
      h_r         <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 3; i++) cs_r[i] <= '0;
    end else begin
      // A word loaded in the emit state keeps valid high on its own.
      if (out_take && state_r != S_EMIT) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            cur_r[0] <= in_vx;
            cur_r[1] <= in_vy;
            cur_r[2] <= in_vz;
            last_r   <= in_last;
            state_r  <= S_VTX;
          end
        end
        S_VTX: begin
          k_r   <= '0;
          h_r   <= 1'b0;
          job_r <= JOB_EDGE;
          state_r <= (cnt_r != '0) ? S_MUL : S_UPD;
        end
        S_MUL: state_r <= S_MWAIT;
        S_MWAIT: begin
          if (mul_done) begin
            if (!h_r) begin
              tmp_r   <= prod[NW-2:0];
              h_r     <= 1'b1;
              state_r <= S_MUL;
            end else begin
              if (job_r == JOB_NORMAL) n_r[k_r] <= comp;
              else cs_r[k_r] <= cs_sat;
              h_r <= 1'b0;
              if (k_r == 2'd2) begin
                k_r <= '0;
                case (job_r)
                  JOB_EDGE:  state_r <= S_UPD;
                  JOB_CLOSE: state_r <= S_CLOSED;
                  default:   state_r <= S_NZ;
                endcase
              end else begin
                k_r     <= k_r + 1'b1;
                state_r <= S_MUL;
              end
            end
          end
        end
        S_UPD: begin
          // Keep the first three vertices, track the previous one.
          if (cnt_r != 2'd3) begin
            anc_r[cnt_r][0] <= cur_r[0];
            anc_r[cnt_r][1] <= cur_r[1];
            anc_r[cnt_r][2] <= cur_r[2];
            cnt_r <= cnt_r + 1'b1;
          end
          for (int i = 0; i < 3; i++) prev_r[i] <= cur_r[i];
          if (last_r) begin
            job_r   <= JOB_CLOSE;
            state_r <= S_MUL;
          end else begin
            state_r <= S_IDLE;
          end
        end
        S_CLOSED: begin
          if (cnt_r == 2'd3) begin
            job_r   <= JOB_NORMAL;
            state_r <= S_MUL;
          end else begin
            for (int i = 0; i < 3; i++) nrm_r[i] <= '0;
            area_r  <= '0;
            deg_r   <= 1'b1;
            state_r <= S_EMIT;
          end
        end
        S_NZ: begin
          for (int i = 0; i < 3; i++) begin
            m_r[i] <= n_r[i][NW-1] ? NW'(-n_r[i]) : NW'(n_r[i]);
          end
          if (all_zero) begin
            for (int i = 0; i < 3; i++) nrm_r[i] <= '0;
            area_r  <= '0;
            deg_r   <= 1'b1;
            state_r <= S_EMIT;
          end else begin
            state_r <= S_NORM;
          end
        end
        S_NORM: begin
          // Shift all three together until the largest lies in [2^29, 2^30).
          if (any_hi) begin
            for (int i = 0; i < 3; i++) m_r[i] <= m_r[i] >> 1;
          end else if (all_lo) begin
            for (int i = 0; i < 3; i++) m_r[i] <= m_r[i] << 1;
          end else begin
            sq_r    <= '0;
            k_r     <= '0;
            state_r <= S_SQ;
          end
        end
        S_SQ: state_r <= S_SQW;
        S_SQW: begin
          if (mul_done) begin
            sq_r <= sq_r + prod[pa3_pkg::SQ_W-1:0];
            if (k_r == 2'd2) begin
              k_r     <= '0;
              state_r <= S_ROOT;
            end else begin
              k_r     <= k_r + 1'b1;
              state_r <= S_SQ;
            end
          end
        end
        S_ROOT: state_r <= S_ROOTW;
        S_ROOTW: begin
          if (sqrt_done) begin
            root_r  <= sqrt_root;
            state_r <= S_DIV;
          end
        end
        S_DIV: state_r <= S_DIVW;
        S_DIVW: begin
          if (div_done) begin
            nrm_r[k_r] <= q_signed;
            if (k_r == 2'd2) begin
              k_r     <= '0;
              dacc_r  <= '0;
              state_r <= S_DOT;
            end else begin
              k_r     <= k_r + 1'b1;
              state_r <= S_DIV;
            end
          end
        end
        S_DOT: state_r <= S_DOTW;
        S_DOTW: begin
          if (mul_done) begin
            dacc_r <= dacc_r + pa3_pkg::DACC_W'(prod);
            if (k_r == 2'd2) begin
              k_r     <= '0;
              state_r <= S_FIN;
            end else begin
              k_r     <= k_r + 1'b1;
              state_r <= S_DOT;
            end
          end
        end
        S_FIN: begin
          area_r  <= area_sat;
          deg_r   <= 1'b0;
          state_r <= S_EMIT;
        end
        S_EMIT: begin
          // Hold until the output register is free, then drop polygon state.
          if (!out_valid_r || !out_stall) begin
            out_area       <= area_r;
            out_normal_x   <= nrm_r[0];
            out_normal_y   <= nrm_r[1];
            out_normal_z   <= nrm_r[2];
            out_degenerate <= deg_r;
            out_valid_r    <= 1'b1;
            cnt_r          <= '0;
            for (int i = 0; i < 3; i++) cs_r[i] <= '0;
            state_r        <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;

endmodule

[sv/pa3_mul.sv]
// Shift-add multiplier: signed operands, one bit of b per cycle.
module pa3_mul (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  input  logic signed [pa3_pkg::MUL_AW-1:0]    a,
  input  logic signed [pa3_pkg::MUL_BW-1:0]    b,
  output logic                                 done,
  output logic signed [pa3_pkg::PROD_W-1:0]    prod
);

  localparam int AW = pa3_pkg::MUL_AW;
  localparam int BW = pa3_pkg::MUL_BW;
  localparam int PW = AW + BW;

  logic                            busy_r;
  logic                            done_r;
  logic                            neg_r;
  logic [pa3_pkg::MUL_CNT_W-1:0]   cnt_r;
  logic [AW-1:0]                   a_r;
  logic [PW-1:0]                   p_r;
  logic [AW-1:0]                   a_mag;
  logic [BW-1:0]                   b_mag;
  logic [AW:0]                     sum;

  assign a_mag = a[AW-1] ? (~a + AW'(1)) : a;
  assign b_mag = b[BW-1] ? (~b + BW'(1)) : b;
  assign sum   = {1'b0, p_r[PW-1:BW]} + (p_r[0] ? {1'b0, a_r} : {(AW+1){1'b0}});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        a_r    <= a_mag;
        p_r    <= {{AW{1'b0}}, b_mag};
        neg_r  <= a[AW-1] ^ b[BW-1];
      end else if (busy_r) begin
        p_r   <= {sum, p_r[BW-1:1]};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == pa3_pkg::MUL_CNT_W'(BW-1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign prod = neg_r ? ({(PW+1){1'b0}} - {1'b0, p_r}) : {1'b0, p_r};

endmodule

[sv/pa3_sqrt.sv]
// Floor integer square root, one result bit per cycle.
module pa3_sqrt (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [pa3_pkg::SQ_W-1:0]       x,
  output logic                           done,
  output logic [pa3_pkg::ROOT_W-1:0]     root
);

  localparam int W = pa3_pkg::SQ_W;

  logic                             busy_r;
  logic                             done_r;
  logic [pa3_pkg::SQRT_CNT_W-1:0]   cnt_r;
  logic [W-1:0]                     x_r;
  logic [W-1:0]                     r_r;
  logic [W-1:0]                     bit_r;
  logic [W-1:0]                     t;

  assign t = r_r + bit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        x_r    <= x;
        r_r    <= '0;
        bit_r  <= W'(1) << (W - 2);
      end else if (busy_r) begin
        if (x_r >= t) begin
          x_r <= x_r - t;
          r_r <= (r_r >> 1) + bit_r;
        end else begin
          r_r <= r_r >> 1;
        end
        bit_r <= bit_r >> 2;
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == pa3_pkg::SQRT_CNT_W'(pa3_pkg::SQRT_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign root = r_r[pa3_pkg::ROOT_W-1:0];

endmodule

[sv/pa3_div.sv]
// Restoring divider, one quotient bit per cycle.
module pa3_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [pa3_pkg::DIV_NW-1:0]    num,
  input  logic [pa3_pkg::DIV_DW-1:0]    den,
  output logic                          done,
  output logic [pa3_pkg::DIV_NW-1:0]    quo
);

  localparam int NW = pa3_pkg::DIV_NW;
  localparam int DW = pa3_pkg::DIV_DW;

  logic                            busy_r;
  logic                            done_r;
  logic [pa3_pkg::DIV_CNT_W-1:0]   cnt_r;
  logic [NW-1:0]                   q_r;
  logic [DW-1:0]                   rem_r;
  logic [DW-1:0]                   den_r;
  logic [DW:0]                     sh;
  logic [DW:0]                     diff;
  logic                            ge;

  assign sh   = {rem_r, q_r[NW-1]};
  assign ge   = sh >= {1'b0, den_r};
  assign diff = sh - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        q_r    <= num;
        rem_r  <= '0;
        den_r  <= den;
      end else if (busy_r) begin
        rem_r <= ge ? diff[DW-1:0] : sh[DW-1:0];
        q_r   <= {q_r[NW-2:0], ge};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == pa3_pkg::DIV_CNT_W'(NW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = q_r;

endmodule
